// ===== design/assert_macros.svh =====
// Assertion macros shared by the raster-to-block RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// Condition that must never hold
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== design/r2b8_pkg.sv =====
// Shared constants and controller/datapath interface types for the 8x8 block reorderer
`default_nettype none

package r2b8_pkg;

    // default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // block geometry: 8x8, so 3 index bits per dimension
    localparam int BLK_LOG2   = 3;
    localparam int BLK_ROWS   = 8;
    localparam int BLK_PIXELS = 64;
    localparam int IDX_W      = 6;

    // field widths
    localparam int PIX_W      = 8;
    localparam int BCOL_W     = 7;
    localparam int BROW_W     = 9;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 1;

    // smallest usable frame size, also the reset size
    localparam int MIN_SIZE = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_en;     // input beat accepted: store pixel, advance counters
        logic rd_issue;  // read one pixel of the finished block
    } r2b8_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic blk_complete; // pixel at the head closes an 8x8 block
        logic slot_free;    // read stage can take a new pixel this cycle
        logic idx_last;     // next read is the 64th of the block
    } r2b8_stat_t;

endpackage

`default_nettype wire

// ===== design/raster_to_block_8x8_unit.sv =====
// Top level: raster pixel stream in, 8x8 blocks out, row by row within each block
//
//  port group   dir   contents
//  s_*          in    one raster pixel per beat (s_pixel_in)
//  m_*          out   block pixel, block column/row index, last-in-block flag
//  cfg_*        in    write-only registers: 0 image_width, 1 image_height
//
//  Input beats are taken one per cycle while no block is being read out. The
//  beat that closes a block drops s_ready for its readout: the line store has
//  one port, and the block is read one pixel per cycle when not stalled. m_valid
//  rises with the block's first pixel via the state, read-stage and output registers.
//  With m_ready low the read stalls once two pixels are buffered; input resumes
//  once the 64th read is issued. Synchronous aresetn clears counters, sizes to 8.
`default_nettype none

module raster_to_block_8x8_unit
    import r2b8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIX_W-1:0]           m_pixel_out,
    output logic [BCOL_W-1:0]          m_block_col,
    output logic [BROW_W-1:0]          m_block_row,
    output logic                       m_last_in_block
);

    r2b8_cmd_t  cmd;
    r2b8_stat_t stat;

    r2b8_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    r2b8_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_pixel_in      (s_pixel_in),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_block_col     (m_block_col),
        .m_block_row     (m_block_row),
        .m_last_in_block (m_last_in_block)
    );

endmodule

`default_nettype wire

// ===== design/r2b8_ctrl.sv =====
// Controller: accepts input beats, then sequences the 64 reads of a finished block
`default_nettype none
`include "assert_macros.svh"

module r2b8_ctrl
    import r2b8_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire r2b8_stat_t stat,
    output r2b8_cmd_t       cmd
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic state_reg;
    logic state_next;
    logic in_fire;

    // handshake and commands
    assign s_ready      = (state_reg == ST_ACCEPT);
    assign in_fire      = s_valid && s_ready;
    assign cmd.wr_en    = in_fire;
    assign cmd.rd_issue = (state_reg == ST_EMIT) && stat.slot_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (in_fire && stat.blk_complete) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.rd_issue && stat.idx_last) begin
                    state_next = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

    // a closing pixel always starts a block readout
    `ASSERT_NEXT(a_enter_emit, in_fire && stat.blk_complete, state_reg == ST_EMIT)
    // the 64th read hands control back to the input side
    `ASSERT_NEXT(a_leave_emit, cmd.rd_issue && stat.idx_last, state_reg == ST_ACCEPT)

endmodule

`default_nettype wire

// ===== design/r2b8_datapath.sv =====
// Datapath: config registers, raster counters, line store and output pipeline
`default_nettype none
`include "assert_macros.svh"

module r2b8_datapath
    import r2b8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [PIX_W-1:0]      s_pixel_in,
    input  wire r2b8_cmd_t             cmd,
    output r2b8_stat_t                 stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIX_W-1:0]           m_pixel_out,
    output logic [BCOL_W-1:0]          m_block_col,
    output logic [BROW_W-1:0]          m_block_row,
    output logic                       m_last_in_block
);

    localparam int CW    = $clog2(MAX_WIDTH);      // column counter
    localparam int WW    = $clog2(MAX_WIDTH + 1);  // clamped width
    localparam int RW    = $clog2(MAX_HEIGHT);     // row counter
    localparam int HW    = $clog2(MAX_HEIGHT + 1); // clamped height
    localparam int DEPTH = BLK_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_WIDTH_W'(MIN_SIZE);
            height_reg <= CFG_HEIGHT_W'(MIN_SIZE);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate sizes to the supported range, and round down to whole blocks
    logic [WW-1:0] w_sat, w_use;
    logic [HW-1:0] h_sat, h_use;

    always_comb begin
        if (width_reg < CFG_WIDTH_W'(MIN_SIZE)) begin
            w_sat = WW'(MIN_SIZE);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(width_reg);
        end
        if (height_reg < CFG_HEIGHT_W'(MIN_SIZE)) begin
            h_sat = HW'(MIN_SIZE);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_sat = HW'(MAX_HEIGHT);
        end else begin
            h_sat = HW'(height_reg);
        end
        w_use = {w_sat[WW-1:BLK_LOG2], BLK_LOG2'(0)};
        h_use = {h_sat[HW-1:BLK_LOG2], BLK_LOG2'(0)};
    end

    // raster position of the next input pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          keep;

    assign col_inc = WW'(col_reg) + WW'(1);
    assign row_inc = HW'(row_reg) + HW'(1);
    assign keep    = (WW'(col_reg) < w_use) && (HW'(row_reg) < h_use);
    assign stat.blk_complete = keep && (&row_reg[BLK_LOG2-1:0])
                                    && (&col_reg[BLK_LOG2-1:0]);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.wr_en) begin
            if (col_inc >= w_sat) begin
                col_next = '0;
                if (row_inc >= h_sat) begin
                    row_next = '0;
                end else begin
                    row_next = RW'(row_inc);
                end
            end else begin
                col_next = CW'(col_inc);
                // height shrunk under a running frame
                if (HW'(row_reg) >= h_sat) begin
                    row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // position of the block being read out
    logic [CW-1:0] blk_col_reg;
    logic [RW-1:0] blk_row_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && stat.blk_complete) begin
            blk_col_reg <= col_reg;
            blk_row_reg <= row_reg;
        end
    end

    // readout index: low 3 bits column in block, high 3 bits row in block
    logic [IDX_W-1:0] emit_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
        end else if (cmd.rd_issue) begin
            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
        end
    end

    assign stat.idx_last = (emit_idx_reg == IDX_W'(BLK_PIXELS - 1));

    // line store addressing: column-major, eight band rows per column
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] rcol;
    logic [CW-1:0] bx_full;
    logic [RW-1:0] by_full;

    always_comb begin
        rcol = blk_col_reg;
        rcol[BLK_LOG2-1:0] = emit_idx_reg[BLK_LOG2-1:0];
        raddr   = {rcol, emit_idx_reg[IDX_W-1:BLK_LOG2]};
        waddr   = {col_reg, row_reg[BLK_LOG2-1:0]};
        bx_full = blk_col_reg >> BLK_LOG2;
        by_full = blk_row_reg >> BLK_LOG2;
    end

    // line store with registered read port
    logic [PIX_W-1:0] store_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && keep) begin
            store_mem[waddr] <= s_pixel_in;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    // read stage sideband
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg;
    logic [BCOL_W-1:0] rd_bcol_reg;
    logic [BROW_W-1:0] rd_brow_reg;
    logic              adv;

    assign adv            = !m_valid || m_ready;
    assign stat.slot_free = !rd_valid_reg || adv;
    assign rd_valid_next  = cmd.rd_issue || (rd_valid_reg && !adv);

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_last_reg <= stat.idx_last;
            rd_bcol_reg <= BCOL_W'(bx_full);
            rd_brow_reg <= BROW_W'(by_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rd_valid_reg) begin
            m_pixel_out     <= rd_data_reg;
            m_block_col     <= rd_bcol_reg;
            m_block_row     <= rd_brow_reg;
            m_last_in_block <= rd_last_reg;
        end
    end

    // store is single ported: a write and a read never meet
    `ASSERT_NEVER(a_no_rw_clash, cmd.wr_en && cmd.rd_issue)
    // reads are only issued into a free stage
    `ASSERT_IMPLIES(a_issue_room, cmd.rd_issue, stat.slot_free)
    // a blocked read stage keeps its pixel
    `ASSERT_NEXT(a_stage_hold, rd_valid_reg && !adv, rd_valid_reg && $stable(rd_data_reg))

endmodule

`default_nettype wire

// ===== dv/raster_to_block_8x8_unit_test.sv =====
// Self-checking testbench for the 8x8 raster-to-block reorderer
`timescale 1ns / 100ps

module raster_to_block_8x8_unit_test
    import r2b8_pkg::*;
();

    localparam int          MAX_W         = DEF_MAX_WIDTH;
    localparam int          MAX_H         = DEF_MAX_HEIGHT;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT   = 5000000;
    localparam int unsigned ITEM_TARGET   = 230;

    typedef enum logic [1:0] {OP_PIXEL, OP_CFG, OP_DRAIN} stim_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_STARVE} rx_mode_t;

    typedef struct packed {
        stim_kind_t            kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
    } stim_op_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [BCOL_W-1:0] bcol;
        logic [BROW_W-1:0] brow;
        logic              last;
    } block_beat_t;

    // DUT signals
    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic [BCOL_W-1:0]     m_block_col;
    logic [BROW_W-1:0]     m_block_row;
    logic                  m_last_in_block;

    // stimulus and scoreboard state
    stim_op_t    stim_ops[$];
    block_beat_t block_beats_due[$];
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    logic        pix_taken      = 1'b0;
    int unsigned quiet_cycles   = 0;
    int unsigned gap_left       = 0;
    int unsigned burst_left     = 0;
    rx_mode_t    rx_mode        = RX_OPEN;
    int unsigned rx_span        = 0;
    int unsigned pixels_planned = 0;

    // predictor copy of the block state
    logic [PIX_W-1:0]        band_store [BLK_ROWS*MAX_W];
    logic [CFG_WIDTH_W-1:0]  width_cfg  = CFG_WIDTH_W'(MIN_SIZE);
    logic [CFG_HEIGHT_W-1:0] height_cfg = CFG_HEIGHT_W'(MIN_SIZE);
    int unsigned             fill_col   = 0;
    int unsigned             fill_row   = 0;

    // planner copy of the counters, used to place config writes safely
    int unsigned plan_w   = MIN_SIZE;
    int unsigned plan_h   = MIN_SIZE;
    int unsigned plan_col = 0;
    int unsigned plan_row = 0;

    raster_to_block_8x8_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_block_col     (m_block_col),
        .m_block_row     (m_block_row),
        .m_last_in_block (m_last_in_block)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // size registers saturate to MIN_SIZE..hi
    function automatic int unsigned eff_size(input int unsigned raw, input int unsigned hi);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // raster position after one pixel; a position past a shrunken size wraps here
    task automatic step_position(inout int unsigned col, inout int unsigned row,
                                 input int unsigned w, input int unsigned h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end else if (row >= h) begin
            row = 0;
        end
    endtask

    // store one pixel; on the bottom-right pixel of a block, queue its 64 beats
    task automatic reorder_pixel(input logic [PIX_W-1:0] pix);
        int unsigned w, h, band_row, base;
        block_beat_t beat;
        w = eff_size(width_cfg, MAX_W);
        h = eff_size(height_cfg, MAX_H);
        if (fill_col < (w / BLK_ROWS) * BLK_ROWS && fill_row < (h / BLK_ROWS) * BLK_ROWS) begin
            band_row = fill_row % BLK_ROWS;
            band_store[band_row * MAX_W + fill_col] = pix;
            if (band_row == BLK_ROWS - 1 && fill_col % BLK_ROWS == BLK_ROWS - 1) begin
                base = fill_col - (BLK_ROWS - 1);
                for (int r = 0; r < BLK_ROWS; r++) begin
                    for (int c = 0; c < BLK_ROWS; c++) begin
                        beat.pixel = band_store[r * MAX_W + base + c];
                        beat.bcol  = BCOL_W'(fill_col / BLK_ROWS);
                        beat.brow  = BROW_W'(fill_row / BLK_ROWS);
                        beat.last  = (r == BLK_ROWS - 1) && (c == BLK_ROWS - 1);
                        block_beats_due = {block_beats_due, beat};
                    end
                end
            end
        end
        step_position(fill_col, fill_row, w, h);
    endtask

    // queue builders; the planner tracks counters so config lands where intended
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        stim_op_t op;
        op = '{kind: OP_PIXEL, addr: '0, data: '0, pixel: pix};
        stim_ops = {stim_ops, op};
        pixels_planned++;
        step_position(plan_col, plan_row, eff_size(plan_w, MAX_W), eff_size(plan_h, MAX_H));
    endtask

    task automatic push_cfg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        stim_op_t op;
        op = '{kind: OP_CFG, addr: addr, data: CFG_DATA_W'(value), pixel: '0};
        stim_ops = {stim_ops, op};
        if (addr == REG_IMAGE_WIDTH)
            plan_w = value % (1 << CFG_WIDTH_W);
        else
            plan_h = value % (1 << CFG_HEIGHT_W);
    endtask

    task automatic push_drain();
        stim_op_t op;
        op = '{kind: OP_DRAIN, addr: '0, data: '0, pixel: '0};
        stim_ops = {stim_ops, op};
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // input driver: bursts and gaps; config and drains wait for a quiet block
    always @(negedge aclk) begin : pixel_driver
        logic                  next_valid;
        logic [PIX_W-1:0]      next_pixel;
        logic                  next_wr;
        logic [CFG_ADDR_W-1:0] next_addr;
        logic [CFG_DATA_W-1:0] next_data;
        stim_op_t              op;
        next_valid = s_valid;
        next_pixel = s_pixel_in;
        next_wr    = 1'b0;
        next_addr  = cfg_addr;
        next_data  = cfg_wdata;
        if (aresetn) begin
            if (s_valid && pix_taken)
                next_valid = 1'b0;
            if (block_beats_due.size() == 0 && !s_valid) begin
                if (quiet_cycles < SETTLE_CYCLES)
                    quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (stim_ops.size() != 0) begin
                    case (stim_ops[0].kind)
                        OP_PIXEL: begin
                            op         = stim_ops.pop_front();
                            next_valid = 1'b1;
                            next_pixel = op.pixel;
                            if (burst_left != 0) begin
                                burst_left--;
                            end else begin
                                burst_left = $urandom_range(1, 40);
                                if ($urandom_range(0, 3) == 0)
                                    gap_left = 0;
                                else if ($urandom_range(0, 7) == 0)
                                    gap_left = 30;
                                else
                                    gap_left = $urandom_range(1, 12);
                            end
                        end
                        default: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                op = stim_ops.pop_front();
                                if (op.kind == OP_CFG) begin
                                    next_wr   = 1'b1;
                                    next_addr = op.addr;
                                    next_data = op.data;
                                    if (op.addr == REG_IMAGE_WIDTH)
                                        width_cfg = op.data[CFG_WIDTH_W-1:0];
                                    else
                                        height_cfg = op.data[CFG_HEIGHT_W-1:0];
                                end
                                quiet_cycles = 0;
                            end
                        end
                    endcase
                end
            end
        end
        s_valid    <= next_valid;
        s_pixel_in <= next_pixel;
        cfg_wr_en  <= next_wr;
        cfg_addr   <= next_addr;
        cfg_wdata  <= next_data;
    end

    // result sink: ready pattern switches among open, coin flip, sparse and starved
    always @(negedge aclk) begin : result_sink
        logic next_ready;
        if (rx_span == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_span = $urandom_range(8, 150);
        end
        rx_span--;
        case (rx_mode)
            RX_OPEN:   next_ready = 1'b1;
            RX_COIN:   next_ready = ($urandom_range(0, 1) == 1);
            RX_SPARSE: next_ready = (rx_span % 4 == 0);
            default:   next_ready = (rx_span % 32 == 0);
        endcase
        m_ready <= next_ready;
    end

    // monitor: predict on input beats, check output beats, watch the cycle limit
    always @(posedge aclk) begin : beat_monitor
        block_beat_t want;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d block beats still due", $time, block_beats_due.size());
            $display("raster_to_block_8x8_unit_test: FAIL");
            $finish;
        end else begin
            cycle_count++;
            pix_taken = aresetn && s_valid && s_ready;
            if (pix_taken)
                reorder_pixel(s_pixel_in);
            if (aresetn && m_valid && m_ready) begin
                if (block_beats_due.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, ", $time,
                             "actual pixel=%0d col=%0d row=%0d last=%0d",
                             m_pixel_out, m_block_col, m_block_row, m_last_in_block);
                    fail_count++;
                end else begin
                    want = block_beats_due.pop_front();
                    check_field("pixel_out", 16'(want.pixel), 16'(m_pixel_out));
                    check_field("block_col", 16'(want.bcol), 16'(m_block_col));
                    check_field("block_row", 16'(want.brow), 16'(m_block_row));
                    check_field("last_in_block", 16'(want.last), 16'(m_last_in_block));
                end
            end
        end
    end

    // stimulus plan, reset, and end of run
    initial begin : stimulus_and_end
        int unsigned k, frame_len, mid_at, pause_at;

        // undersized registers saturate to 8x8; extreme pixel values
        push_cfg(REG_IMAGE_WIDTH, 5);
        push_cfg(REG_IMAGE_HEIGHT, 3);
        for (k = 0; k < 64; k++) begin
            case (k % 4)
                0:       push_pixel(8'h00);
                1:       push_pixel(8'hFF);
                2:       push_pixel(8'h55);
                default: push_pixel(8'hAA);
            endcase
        end
        push_drain();

        // oversized registers saturate to the maximum
        push_cfg(REG_IMAGE_WIDTH, 2047);
        push_cfg(REG_IMAGE_HEIGHT, 8191);
        for (k = 0; k < 12; k++)
            push_pixel(PIX_W'($urandom_range(0, 255)));
        // width shrinks under the current column: wraps on the next pixel
        push_cfg(REG_IMAGE_WIDTH, 8);
        while (plan_row != 8 || plan_col != 3)
            push_pixel(PIX_W'($urandom_range(0, 255)));
        // height shrinks under the current row: wraps mid-row
        push_cfg(REG_IMAGE_HEIGHT, 8);
        do begin
            push_pixel(PIX_W'($urandom_range(0, 255)));
        end while (plan_col != 0 || plan_row != 0);

        // random frames; mid-frame width changes only shrink it, so every block
        // reads line store entries that have been written
        while (pixels_planned < ITEM_TARGET) begin
            case ($urandom_range(0, 6))
                0:       push_cfg(REG_IMAGE_WIDTH, $urandom_range(0, 7));
                1:       push_cfg(REG_IMAGE_WIDTH, $urandom_range(9, 15));
                default: push_cfg(REG_IMAGE_WIDTH, $urandom_range(8, 20));
            endcase
            case ($urandom_range(0, 6))
                0:       push_cfg(REG_IMAGE_HEIGHT, $urandom_range(0, 7));
                1:       push_cfg(REG_IMAGE_HEIGHT, $urandom_range(13, 18));
                default: push_cfg(REG_IMAGE_HEIGHT, $urandom_range(8, 12));
            endcase
            frame_len = eff_size(plan_w, MAX_W) * eff_size(plan_h, MAX_H);
            mid_at    = ($urandom_range(0, 9) < 4) ? $urandom_range(1, frame_len - 1) : 0;
            pause_at  = ($urandom_range(0, 9) < 3) ? $urandom_range(1, frame_len - 1) : 0;
            k = 0;
            do begin
                push_pixel(PIX_W'($urandom_range(0, 255)));
                k++;
                if (k == mid_at) begin
                    if ($urandom_range(0, 1) == 1)
                        push_cfg(REG_IMAGE_WIDTH, $urandom_range(0, eff_size(plan_w, MAX_W)));
                    else
                        push_cfg(REG_IMAGE_HEIGHT, $urandom_range(0, 18));
                end
                if (k == pause_at)
                    push_drain();
            end while (plan_col != 0 || plan_row != 0);
        end

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // drain everything, then give stray beats time to show up
        while (stim_ops.size() != 0 || s_valid)
            @(negedge aclk);
        while (block_beats_due.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("raster_to_block_8x8_unit_test: PASS");
        else
            $display("raster_to_block_8x8_unit_test: FAIL");
        $finish;
    end

endmodule
